[rtl/core/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, register indexes and constants of the Mandelbrot pixel shader.
// ----------------------------------------------------------------------------
package mps_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] REG_X_STEP   = 3'd2;
  localparam logic [2:0] REG_Y_STEP   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER = 3'd4;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] RST_X_ORIGIN = -32'sd563714458;
  localparam logic signed [31:0] RST_Y_ORIGIN = -32'sd322122547;
  localparam logic [30:0]        RST_X_STEP   = 31'd134218;
  localparam logic [30:0]        RST_Y_STEP   = 31'd134218;
  localparam logic [15:0]        RST_MAX_ITER = 16'd500;

  // 4 * 255^2, the scale of the escape count in the gray level search.
  localparam logic [17:0] GRAY_SCALE = 18'd260100;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        max_iter;
  } cfg_t;

  // One point of the complex plane, handed from the front end to the back end.
  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } point_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

[rtl/core/mps_front.sv]
// ----------------------------------------------------------------------------
// mps_front
// Accepts pixel positions, clamps them and maps them to points of the plane.
// ----------------------------------------------------------------------------
module mps_front import mps_pkg::*; #(
  parameter int MAX_COLS = 8192,
  parameter int MAX_ROWS = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [12:0] col_i,
  input  logic [12:0] row_i,
  output logic        pt_valid_o,
  input  logic        pt_ready_i,
  output point_t      pt_o
);

  localparam logic [16:0] COL_LIM = 17'(MAX_COLS - 1);
  localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS - 1);

  logic        valid_r;
  point_t      pt_r;
  logic [12:0] col_c;
  logic [12:0] row_c;
  logic [43:0] prod_x;
  logic [43:0] prod_y;
  logic [63:0] sum_x;
  logic [63:0] sum_y;
  point_t      pt_nxt;

  always_comb begin
    col_c  = ({4'd0, col_i} > COL_LIM) ? COL_LIM[12:0] : col_i;
    row_c  = ({4'd0, row_i} > ROW_LIM) ? ROW_LIM[12:0] : row_i;
    prod_x = 44'(col_c) * 44'(cfg_i.x_step);
    prod_y = 44'(row_c) * 44'(cfg_i.y_step);
    sum_x  = {{32{cfg_i.x_origin[31]}}, cfg_i.x_origin} + {20'd0, prod_x};
    sum_y  = {{32{cfg_i.y_origin[31]}}, cfg_i.y_origin} + {20'd0, prod_y};
    pt_nxt.cr = sat32(sum_x);
    pt_nxt.ci = sat32(sum_y);
  end

  assign in_ready_o = !valid_r || pt_ready_i;
  assign pt_valid_o = valid_r;
  assign pt_o       = pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready_o) begin
      valid_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready_o && in_valid_i) begin
      pt_r <= pt_nxt;
    end
  end

endmodule

[rtl/core/mps_queue.sv]
// ----------------------------------------------------------------------------
// mps_queue
// Two-entry queue of points between the front end and the back end.
// ----------------------------------------------------------------------------
module mps_queue import mps_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  point_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output point_t pop_data_o
);

  point_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_r != 2'd2);
  assign pop_valid_o  = (count_r != 2'd0);
  assign pop_data_o   = mem_r[rd_ptr_r];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

[rtl/core/mps_gray.sv]
// ----------------------------------------------------------------------------
// mps_gray
// Bit-by-bit search for the rounded 255*sqrt(t/m), a square step then a compare step per bit.
// ----------------------------------------------------------------------------
module mps_gray import mps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [15:0] t_i,
  input  logic [15:0] m_i,
  output logic        done_o,
  output logic [7:0]  gray_o
);

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_SQ   = 2'd1;
  localparam logic [1:0] G_CMP  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [33:0] n_r, n_nxt;
  logic [15:0] m_r, m_nxt;
  logic [7:0]  g_r, g_nxt;
  logic [7:0]  bit_r, bit_nxt;
  logic [17:0] hh_r, hh_nxt;
  logic [7:0]  trial;
  logic [8:0]  h;
  logic [33:0] lhs;

  // The largest g with (2g-1)^2 * m <= 4 * 255^2 * t is the rounded value.
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    g_nxt     = g_r;
    bit_nxt   = bit_r;
    trial     = g_r | bit_r;
    h         = {trial, 1'b0} - 9'd1;
    hh_nxt    = 18'(h) * 18'(h);
    lhs       = 34'(hh_r) * 34'(m_r);
    done_o    = 1'b0;
    case (state_r)
      G_IDLE: begin
        if (start_i) begin
          n_nxt     = 34'(GRAY_SCALE) * 34'(t_i);
          m_nxt     = m_i;
          g_nxt     = 8'd0;
          bit_nxt   = 8'h80;
          state_nxt = G_SQ;
        end
      end
      G_SQ: begin
        state_nxt = G_CMP;
      end
      G_CMP: begin
        if (lhs <= n_r) begin
          g_nxt = trial;
        end
        if (bit_r[0]) begin
          done_o    = 1'b1;
          state_nxt = G_IDLE;
        end else begin
          bit_nxt   = bit_r >> 1;
          state_nxt = G_SQ;
        end
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase
  end

  assign gray_o = g_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    m_r   <= m_nxt;
    g_r   <= g_nxt;
    bit_r <= bit_nxt;
    if (state_r == G_SQ) begin
      hh_r <= hh_nxt;
    end
  end

endmodule

[rtl/core/mps_back.sv]
// ----------------------------------------------------------------------------
// mps_back
// Escape-time iteration engine with the gray level unit and output register.
// ----------------------------------------------------------------------------
module mps_back import mps_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg_i,
  input  logic        pt_valid_i,
  output logic        pt_ready_o,
  input  point_t      pt_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  gray_o,
  output logic [15:0] count_o
);

  localparam bit          CAN_ESC = (2 * FRAC_BITS + 2) < 64;
  localparam logic [63:0] BOUND   = CAN_ESC ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_GRAY = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] cr_r, ci_r;
  logic signed [31:0] zr_r, zr_nxt;
  logic signed [31:0] zi_r, zi_nxt;
  logic [15:0]        t_r, t_nxt;
  logic signed [63:0] prr_r, pii_r, pri_r;
  logic [7:0]         gray_r, gray_nxt;
  logic [7:0]         out_gray_r;
  logic [15:0]        out_count_r;
  logic               load_pt;
  logic               load_out;
  logic               gray_start;
  logic               gray_done;
  logic [7:0]         gray_res;
  logic [63:0]        mag2;
  logic signed [63:0] re;
  logic signed [63:0] re_sh;
  logic signed [63:0] im_sh;
  logic signed [63:0] re_new;
  logic signed [63:0] im_new;

  mps_gray u_gray (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (gray_start),
    .t_i     (t_r),
    .m_i     (cfg_i.max_iter),
    .done_o  (gray_done),
    .gray_o  (gray_res)
  );

  always_comb begin
    mag2   = 64'(prr_r) + 64'(pii_r);
    re     = prr_r - pii_r;
    re_sh  = re >>> FRAC_BITS;
    im_sh  = pri_r >>> (FRAC_BITS - 1);
    re_new = re_sh + 64'(cr_r);
    im_new = im_sh + 64'(ci_r);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    t_nxt         = t_r;
    gray_nxt      = gray_r;
    load_pt       = 1'b0;
    load_out      = 1'b0;
    gray_start    = 1'b0;
    if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (pt_valid_i) begin
          load_pt   = 1'b1;
          zr_nxt    = pt_i.cr;
          zi_nxt    = pt_i.ci;
          t_nxt     = 16'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (t_r == cfg_i.max_iter) begin
          gray_nxt  = 8'd0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (CAN_ESC && (mag2 > BOUND)) begin
          gray_start = 1'b1;
          state_nxt  = S_GRAY;
        end else begin
          zr_nxt    = sat32(re_new);
          zi_nxt    = sat32(im_new);
          t_nxt     = t_r + 16'd1;
          state_nxt = S_MUL;
        end
      end
      S_GRAY: begin
        if (gray_done) begin
          gray_nxt  = gray_res;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready_i) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pt_ready_o  = (state_r == S_IDLE);
  assign out_valid_o = out_valid_r;
  assign gray_o      = out_gray_r;
  assign count_o     = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    t_r    <= t_nxt;
    gray_r <= gray_nxt;
    if (load_pt) begin
      cr_r <= pt_i.cr;
      ci_r <= pt_i.ci;
    end
    if (state_r == S_MUL) begin
      prr_r <= 64'(zr_r) * 64'(zr_r);
      pii_r <= 64'(zi_r) * 64'(zi_r);
      pri_r <= 64'(zr_r) * 64'(zi_r);
    end
    if (load_out) begin
      out_gray_r  <= gray_r;
      out_count_r <= t_r;
    end
  end

endmodule

[rtl/core/mandelbrot_pixel_shader_top.sv]
// ----------------------------------------------------------------------------
// mandelbrot_pixel_shader_top
// Each iteration of the back end squares the products, then tests for escape
// and updates z; an escaped pixel then runs the gray level search. The back
// end takes a new pixel only once the last result is in its output register;
// the front end and queue take further pixels while the queue has room.
// Reset: synchronous, active low; clears all handshake state and loads the
// register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_shader_top import mps_pkg::*; #(
  parameter int MAX_COLS  = 8192,
  parameter int MAX_ROWS  = 8192,
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [12:0] pixel_col, [25:13] pixel_row, rest zero
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] gray_level, [23:8] escape_count
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // The front end clamps the position and forms c = origin + position*step in
  // one registered stage. The queue lets it take the next pixels while the
  // back end is still iterating on the current one.

  cfg_t   cfg_r;
  logic   fq_valid;
  logic   fq_ready;
  point_t fq_data;
  logic   qb_valid;
  logic   qb_ready;
  point_t qb_data;
  logic [7:0]  gray;
  logic [15:0] count;

  // Writes are always taken; an index beyond the register list is a no-op.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin <= RST_X_ORIGIN;
      cfg_r.y_origin <= RST_Y_ORIGIN;
      cfg_r.x_step   <= RST_X_STEP;
      cfg_r.y_step   <= RST_Y_STEP;
      cfg_r.max_iter <= RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_ORIGIN: cfg_r.x_origin <= cfg_data;
        REG_Y_ORIGIN: cfg_r.y_origin <= cfg_data;
        REG_X_STEP:   cfg_r.x_step   <= cfg_data[30:0];
        REG_Y_STEP:   cfg_r.y_step   <= cfg_data[30:0];
        REG_MAX_ITER: cfg_r.max_iter <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  mps_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .col_i      (in_tdata[12:0]),
    .row_i      (in_tdata[25:13]),
    .pt_valid_o (fq_valid),
    .pt_ready_i (fq_ready),
    .pt_o       (fq_data)
  );

  mps_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  // The back end runs the iteration, then for an escaped pixel the gray level search, and holds the
  // finished result in its output register until the transfer completes.
  mps_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .pt_valid_i  (qb_valid),
    .pt_ready_o  (qb_ready),
    .pt_i        (qb_data),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .gray_o      (gray),
    .count_o     (count)
  );

  assign out_tdata = {count, gray};

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:8] <= cfg_r.max_iter))
    else $error("escape count above the iteration limit");

  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[23:8] == cfg_r.max_iter)) |-> (out_tdata[7:0] == 8'd0))
    else $error("point inside the set has a nonzero gray level");

  a_escaped_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[23:8] != cfg_r.max_iter) && (out_tdata[23:8] != 16'd0))
    |-> (out_tdata[7:0] != 8'd0))
    else $error("escaped point has a zero gray level");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_valid && !fq_ready) |=> fq_valid)
    else $error("front end dropped a point while the queue was full");
`endif

endmodule
